// File: sv/mshr_pkg.sv
// Shared types and constants for the miss status holding register file.
package mshr_pkg;

  localparam int unsigned NumEntriesDef  = 8;
  localparam int unsigned TargetsDef     = 4;
  localparam int unsigned AddrW          = 32;
  localparam int unsigned TimeW          = 32;
  localparam int unsigned LatW           = 16;
  localparam int unsigned OffW           = 12;
  localparam int unsigned OffBitsW       = 4;
  localparam logic [3:0]  OffBitsReset   = 4'd6;
  localparam int unsigned InDataW        = 88;
  localparam int unsigned OutDataW       = 56;

  // request kinds
  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_FLUSH  = 2'd3
  } kind_t;

  // result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_FREE    = 3'd1;
  localparam logic [2:0] ST_FULL       = 3'd2;
  localparam logic [2:0] ST_LOOKUP_MISS = 3'd3;
  localparam logic [2:0] ST_FLUSH_INV  = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch incoming request
    logic execute;  // evaluate and update table, load result
  } mshr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;     // result register loaded
  } mshr_sts_t;

endpackage

// File: sv/mshr_ctrl.sv
// Controller: sequences capture, execute and result delivery.
module mshr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output mshr_pkg::mshr_cmd_t cmd,
  input  mshr_pkg::mshr_sts_t sts
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_OUT} state_t;

  state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_EXEC;
      S_EXEC: if (sts.done) state_nxt = S_OUT;
      S_OUT:  if (out_tready) state_nxt = in_tvalid ? S_EXEC : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // a new request is taken when idle or as the held result leaves
  assign in_tready   = (state_r == S_IDLE) || (state_r == S_OUT && out_tready);
  assign out_tvalid  = (state_r == S_OUT);
  assign cmd.capture = in_tvalid && in_tready;
  assign cmd.execute = (state_r == S_EXEC);

  // request capture only when the result slot is free or draining
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |-> (state_r != S_EXEC)) else $error("capture during execute");
  // execute is always followed by a result
  a_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |=> out_tvalid) else $error("execute without result");
  // a result is only shown after an execute
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.execute)) else $error("result without execute");

endmodule

// File: sv/mshr_dp.sv
// Datapath: entry table, match and allocate logic, result register.
module mshr_dp #(
  parameter int unsigned NUM_ENTRIES       = mshr_pkg::NumEntriesDef,
  parameter int unsigned TARGETS_PER_ENTRY = mshr_pkg::TargetsDef
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [3:0]              cfg_wr_data,
  input  logic [mshr_pkg::InDataW-1:0] in_data,
  output logic [mshr_pkg::OutDataW-1:0] out_data,
  input  mshr_pkg::mshr_cmd_t     cmd,
  output mshr_pkg::mshr_sts_t     sts
);

  localparam int unsigned EW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int unsigned TW = (TARGETS_PER_ENTRY > 1) ? $clog2(TARGETS_PER_ENTRY) : 1;
  localparam int unsigned CW = $clog2(TARGETS_PER_ENTRY + 1);
  localparam int unsigned BW = $clog2(NUM_ENTRIES + 1);
  localparam int unsigned AW = mshr_pkg::AddrW;

  // configuration
  logic [3:0] offset_bits_r;
  always_ff @(posedge clk) begin
    if (!rst_n)         offset_bits_r <= mshr_pkg::OffBitsReset;
    else if (cfg_wr_en) offset_bits_r <= cfg_wr_data;
  end

  // captured request
  logic [1:0]  kind_r;
  logic [31:0] addr_r, now_r;
  logic [15:0] lat_r;
  logic [2:0]  sel_r;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_data[1:0];
      addr_r <= in_data[33:2];
      now_r  <= in_data[65:34];
      lat_r  <= in_data[81:66];
      sel_r  <= in_data[84:82];
    end
  end

  // table state
  logic [NUM_ENTRIES-1:0] valid_r, full_r;
  logic [CW-1:0]          cnt_r [NUM_ENTRIES];
  logic [AW-1:0]          blk_r [NUM_ENTRIES];
  logic [31:0]            rdy_r [NUM_ENTRIES];
  logic [TARGETS_PER_ENTRY-1:0] tvld_r [NUM_ENTRIES];
  logic [mshr_pkg::OffW-1:0] toff_r [NUM_ENTRIES][TARGETS_PER_ENTRY];
  logic [BW-1:0]          busy_r;

  // address split
  logic [3:0]  ob;
  logic [31:0] mask, blk;
  assign ob   = (offset_bits_r > 4'd12) ? 4'd12 : offset_bits_r;
  assign mask = (32'd1 << ob) - 32'd1;
  assign blk  = addr_r & ~mask;

  // parallel match, free search, due detect
  logic [NUM_ENTRIES-1:0] hit, due;
  logic        hit_any, free_any;
  logic [EW-1:0] hit_idx, free_idx;
  always_comb begin
    hit_any = 1'b0; free_any = 1'b0;
    hit_idx = '0; free_idx = '0;
    for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
      hit[i] = valid_r[i] && (blk_r[i] == blk);
      due[i] = valid_r[i] && (now_r >= rdy_r[i]);
      if (hit[i])     begin hit_any = 1'b1;  hit_idx  = EW'(i); end
      if (!valid_r[i]) begin free_any = 1'b1; free_idx = EW'(i); end
    end
  end

  // saturating ready time
  logic [32:0] tsum;
  logic [31:0] tsat;
  assign tsum = {1'b0, now_r} + {17'd0, lat_r};
  assign tsat = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];

  // flush target, sized to the entry index
  logic [EW-1:0] sel_e;
  logic sel_ok;
  assign sel_e  = EW'(sel_r);
  assign sel_ok = ({29'd0, sel_r} < 32'(NUM_ENTRIES)) && valid_r[sel_e];

  // decision
  logic [2:0]  st;
  logic [2:0]  idx;
  logic [1:0]  slot;
  logic        mrg;
  logic [31:0] rdy;
  logic [NUM_ENTRIES-1:0] freed;
  logic        do_ins, do_alloc;
  logic [EW-1:0] ins_e;
  logic [CW-1:0] ins_cnt;
  always_comb begin
    st = mshr_pkg::ST_OK; idx = '0; slot = '0; mrg = 1'b0; rdy = '0;
    freed = '0; do_ins = 1'b0; do_alloc = 1'b0; ins_e = '0; ins_cnt = '0;
    case (kind_r)
      mshr_pkg::KIND_INSERT: begin
        if (hit_any && full_r[hit_idx]) begin
          st = mshr_pkg::ST_FULL; idx = 3'(hit_idx); rdy = rdy_r[hit_idx];
        end else if (hit_any) begin
          do_ins = 1'b1; ins_e = hit_idx; ins_cnt = cnt_r[hit_idx];
          mrg = 1'b1; rdy = rdy_r[hit_idx];
        end else if (free_any) begin
          do_ins = 1'b1; do_alloc = 1'b1; ins_e = free_idx; ins_cnt = '0; rdy = tsat;
        end else begin
          st = mshr_pkg::ST_NO_FREE;
        end
        if (do_ins) begin
          idx = 3'(ins_e); slot = 2'(ins_cnt);
        end
      end
      mshr_pkg::KIND_LOOKUP: begin
        if (hit_any) begin idx = 3'(hit_idx); rdy = rdy_r[hit_idx]; end
        else st = mshr_pkg::ST_LOOKUP_MISS;
      end
      mshr_pkg::KIND_TICK: freed = due;
      default: begin
        idx = sel_r;
        if (sel_ok) freed[sel_e] = 1'b1;
        else        st = mshr_pkg::ST_FLUSH_INV;
      end
    endcase
  end

  logic [BW-1:0] busy_nxt;
  always_comb begin
    busy_nxt = busy_r + BW'(do_alloc);
    for (int i = 0; i < NUM_ENTRIES; i++) busy_nxt = busy_nxt - BW'(freed[i]);
  end

  // table update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0; full_r <= '0; busy_r <= '0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        cnt_r[i] <= '0; tvld_r[i] <= '0;
      end
    end else if (cmd.execute) begin
      busy_r <= busy_nxt;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        if (freed[i]) begin
          valid_r[i] <= 1'b0; full_r[i] <= 1'b0; cnt_r[i] <= '0; tvld_r[i] <= '0;
        end
      end
      if (do_ins) begin
        if (do_alloc) begin
          valid_r[ins_e] <= 1'b1;
          blk_r[ins_e]   <= blk;
          rdy_r[ins_e]   <= tsat;
        end
        tvld_r[ins_e][ins_cnt[TW-1:0]] <= 1'b1;
        toff_r[ins_e][ins_cnt[TW-1:0]] <= addr_r[mshr_pkg::OffW-1:0] &
                                           mask[mshr_pkg::OffW-1:0];
        cnt_r[ins_e]  <= ins_cnt + CW'(1);
        full_r[ins_e] <= ((ins_cnt + CW'(1)) >= CW'(TARGETS_PER_ENTRY));
      end
    end
  end

  // result register, padded to whole bytes
  logic [mshr_pkg::OutDataW-1:0] res_r;
  logic done_r;
  always_ff @(posedge clk) begin
    if (cmd.execute)
      res_r <= {3'd0, 4'(busy_nxt), 8'(freed), rdy, mrg, slot, idx, st};
  end
  always_ff @(posedge clk) begin
    if (!rst_n) done_r <= 1'b0;
    else        done_r <= cmd.execute;
  end
  assign out_data = res_r;
  assign sts.done = cmd.execute;

  // busy count tracks valid bits
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (32'(busy_r) == 32'($countones(valid_r)))) else $error("busy count drift");
  // a full entry is always valid
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (full_r & ~valid_r) == '0) else $error("full mark on free entry");
  // at most one entry matches
  a_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |-> $onehot0(hit)) else $error("duplicate block address");

endmodule

// File: sv/miss_status_holding_registers.sv
// Top level of the miss status holding register file.
// Tracks outstanding cache-block misses in a small table of entries.
// Input stream (in_*): one request per item; tuser carries the kind
//   (insert, lookup, tick, flush), tdata the address, time, latency, entry.
// Output stream (out_*): exactly one result per request, in order.
// Configuration: cfg_wr_en/cfg_wr_data set the block offset width; the user must
//   write them only while the block is idle, as the block does not enforce it.
// Flow: an accepted request is latched in the capture registers; the execute
//   step then does the parallel match across all entries and the table update
//   and loads the result register. No new request is taken while one is in
//   flight; the next request is taken in the same cycle the result is taken.
// Reset clears all entry valid, full and slot state and the busy count;
//   the offset width returns to 6.
// When the receiver stalls the result holds in the output register and
// no further request is accepted until it leaves.
module miss_status_holding_registers #(
  parameter int unsigned NUM_ENTRIES       = mshr_pkg::NumEntriesDef,
  parameter int unsigned TARGETS_PER_ENTRY = mshr_pkg::TargetsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,  // address, current_time, latency, entry_select, pad
  input  logic [1:0]  in_tuser,  // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata  // status, entry_index, target_slot, merged,
                                 // ready_time, freed_mask, busy_count
);

  mshr_pkg::mshr_cmd_t cmd;
  mshr_pkg::mshr_sts_t sts;
  logic [mshr_pkg::InDataW-1:0] in_data;

  assign in_data = {3'd0, in_tdata[82:0], in_tuser};

  mshr_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
    .cmd, .sts
  );

  mshr_dp #(
    .NUM_ENTRIES(NUM_ENTRIES), .TARGETS_PER_ENTRY(TARGETS_PER_ENTRY)
  ) u_dp (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data, .in_data,
    .out_data(out_tdata), .cmd, .sts
  );

endmodule

// File: bench/tb_miss_status_holding_registers.sv
// Self-checking testbench for the miss status holding register file.
module tb_miss_status_holding_registers;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NENT = 8;
  localparam int NTGT = 4;

  // one request as seen on the input stream
  typedef struct packed {
    mshr_pkg::kind_t kind;
    logic [31:0] addr;
    logic [31:0] now;
    logic [15:0] lat;
    logic [2:0]  sel;
  } mreq_t;

  // one result, with the fields carried in out_tdata
  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  idx;
    logic [1:0]  slot;
    logic        merged;
    logic [31:0] ready;
    logic [7:0]  freed;
    logic [3:0]  busy;
  } mres_t;

  // directed row: request, whether the result is typed in, and that result
  typedef struct {
    mreq_t r;
    bit    fixed;
    mres_t res;
  } drow_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [3:0]  cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [87:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;

  miss_status_holding_registers dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // predictor state
  logic [3:0]  p_offbits;
  logic        p_valid [NENT];
  logic        p_full  [NENT];
  logic [31:0] p_blk   [NENT];
  logic [31:0] p_ready [NENT];
  int          p_cnt   [NENT];
  int          p_busy;

  mres_t expected_q[$];
  int    errors;
  int    checked;
  int    send_idle_pct;
  int    recv_idle_pct;
  bit    hold_off;

  always #5 clk = ~clk;

  initial begin
    #50ms;
    $display("tb_miss_status_holding_registers: FAIL");
    $finish;
  end

  function automatic void mshr_reset_model();
    p_offbits = mshr_pkg::OffBitsReset;
    p_busy = 0;
    for (int i = 0; i < NENT; i++) begin
      p_valid[i] = 0;
      p_full[i] = 0;
      p_cnt[i] = 0;
      p_blk[i] = '0;
      p_ready[i] = '0;
    end
  endfunction

  function automatic void mshr_free(int e);
    p_valid[e] = 0;
    p_full[e] = 0;
    p_cnt[e] = 0;
    if (p_busy > 0) p_busy--;
  endfunction

  // advance the table by one request and return its result
  function automatic mres_t mshr_predict(mreq_t r);
    mres_t o;
    logic [31:0] mask;
    logic [31:0] blk;
    logic [32:0] sum;
    int m;
    int e;
    int b;
    b = (p_offbits > 12) ? 12 : p_offbits;
    mask = (32'd1 << b) - 32'd1;
    blk = r.addr & ~mask;
    o = '{default: '0};
    m = -1;
    for (int i = NENT - 1; i >= 0; i--)
      if (p_valid[i] && p_blk[i] == blk) m = i;
    case (r.kind)
      mshr_pkg::KIND_INSERT: begin
        if (m >= 0 && p_full[m]) begin
          o.status = mshr_pkg::ST_FULL;
          o.idx = 3'(m);
          o.ready = p_ready[m];
        end else begin
          e = -1;
          if (m >= 0) begin
            e = m;
            o.merged = 1;
          end else begin
            for (int i = NENT - 1; i >= 0; i--)
              if (!p_valid[i]) e = i;
            if (e >= 0) begin
              sum = {1'b0, r.now} + {17'd0, r.lat};
              p_valid[e] = 1;
              p_full[e] = 0;
              p_cnt[e] = 0;
              p_blk[e] = blk;
              p_ready[e] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
              p_busy++;
            end
          end
          if (e < 0) begin
            o.status = mshr_pkg::ST_NO_FREE;
          end else begin
            if (p_cnt[e] < NTGT) p_cnt[e]++;
            if (p_cnt[e] >= NTGT) p_full[e] = 1;
            o.idx = 3'(e);
            o.slot = 2'(p_cnt[e] - 1);
            o.ready = p_ready[e];
          end
        end
      end
      mshr_pkg::KIND_LOOKUP: begin
        if (m >= 0) begin
          o.idx = 3'(m);
          o.ready = p_ready[m];
        end else begin
          o.status = mshr_pkg::ST_LOOKUP_MISS;
        end
      end
      mshr_pkg::KIND_TICK: begin
        for (int i = 0; i < NENT; i++)
          if (p_valid[i] && r.now >= p_ready[i]) begin
            mshr_free(i);
            o.freed[i] = 1;
          end
      end
      default: begin
        o.idx = r.sel;
        if (p_valid[r.sel]) begin
          mshr_free(r.sel);
          o.freed[r.sel] = 1;
        end else begin
          o.status = mshr_pkg::ST_FLUSH_INV;
        end
      end
    endcase
    o.busy = 4'(p_busy);
    return o;
  endfunction

  // result side: random stall plus the long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    mres_t got;
    mres_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tdata[2:0];
      got.idx    = out_tdata[5:3];
      got.slot   = out_tdata[7:6];
      got.merged = out_tdata[8];
      got.ready  = out_tdata[40:9];
      got.freed  = out_tdata[48:41];
      got.busy   = out_tdata[52:49];
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %p", $time, got);
      end else begin
        exp_r = expected_q.pop_front();
        checked++;
        if (got != exp_r) begin
          errors++;
          $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
        end
      end
    end
  end

  // offer one request, wait for it to be taken, queue its expectation;
  // valid stays up after acceptance unless the sender idles or drains
  task automatic send_req(mreq_t r, bit fixed = 0, mres_t fres = '{default: '0});
    mres_t p;
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.kind;
    in_tdata  <= {5'd0, r.sel, r.lat, r.now, r.addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    p = mshr_predict(r);
    expected_q.push_back(fixed ? fres : p);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_offbits(logic [3:0] v);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    p_offbits = v;
  endtask

  // random request; addresses mostly come from a small pool so entries merge, mode 1 is fully random
  function automatic mreq_t rand_req(logic [31:0] base, int mode);
    mreq_t r;
    int k;
    r.addr = base + ($urandom_range(5) << 6) + $urandom_range(63);
    if (mode == 1) r.addr = $urandom;
    r.now  = $urandom_range(2000);
    if ($urandom_range(15) == 0) r.now = $urandom;
    r.lat  = 16'($urandom_range(800));
    if ($urandom_range(15) == 0) r.lat = 16'($urandom);
    r.sel  = 3'($urandom_range(7));
    k = $urandom_range(99);
    r.kind = k < 55 ? mshr_pkg::KIND_INSERT : k < 70 ? mshr_pkg::KIND_LOOKUP :
             k < 90 ? mshr_pkg::KIND_TICK : mshr_pkg::KIND_FLUSH;
    return r;
  endfunction

  initial begin
    drow_t dir[$];
    drow_t d;
    logic [31:0] base;
    clk = 0;
    rst_n = 0;
    cfg_wr_en = 0;
    cfg_wr_data = '0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = '0;
    hold_off = 0;
    errors = 0;
    checked = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    mshr_reset_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; fixed rows are obvious after reset
    d = '{r: '{mshr_pkg::KIND_LOOKUP, 32'h0, 32'h0, 16'h0, 3'd0}, fixed: 1,
          res: '{mshr_pkg::ST_LOOKUP_MISS, 0, 0, 0, 0, 0, 0}};
    dir.push_back(d);
    d = '{r: '{mshr_pkg::KIND_FLUSH, 32'h0, 32'h0, 16'h0, 3'd7}, fixed: 1,
          res: '{mshr_pkg::ST_FLUSH_INV, 7, 0, 0, 0, 0, 0}};
    dir.push_back(d);
    d = '{r: '{mshr_pkg::KIND_TICK, 32'h0, 32'hFFFF_FFFF, 16'h0, 3'd0}, fixed: 1,
          res: '{mshr_pkg::ST_OK, 0, 0, 0, 0, 0, 0}};
    dir.push_back(d);
    // saturating ready time at entry 0, then fill its slots
    d = '{r: '{mshr_pkg::KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 16'hFFFF, 3'd0},
          fixed: 1, res: '{mshr_pkg::ST_OK, 0, 0, 0, 32'hFFFF_FFFF, 0, 1}};
    dir.push_back(d);
    for (int i = 0; i < 3; i++) begin
      d = '{r: '{mshr_pkg::KIND_INSERT, 32'hFFFF_FFC0 + i, 32'h0, 16'h0, 3'd0}, fixed: 0,
            res: '{default: '0}};
      dir.push_back(d);
    end
    // matched entry full
    d = '{r: '{mshr_pkg::KIND_INSERT, 32'hFFFF_FFC5, 32'h0, 16'h0, 3'd0}, fixed: 1,
          res: '{mshr_pkg::ST_FULL, 0, 0, 0, 32'hFFFF_FFFF, 0, 1}};
    dir.push_back(d);
    // fill remaining seven entries, then one more finds none free
    for (int i = 1; i < 8; i++) begin
      d = '{r: '{mshr_pkg::KIND_INSERT, i << 6, 32'd100, 16'd0, 3'd0}, fixed: 0,
            res: '{default: '0}};
      dir.push_back(d);
    end
    d = '{r: '{mshr_pkg::KIND_INSERT, 32'h0001_0000, 32'h0, 16'h0, 3'd0}, fixed: 1,
          res: '{mshr_pkg::ST_NO_FREE, 0, 0, 0, 0, 0, 8}};
    dir.push_back(d);
    d = '{r: '{mshr_pkg::KIND_LOOKUP, 32'h0000_0085, 32'h0, 16'h0, 3'd0}, fixed: 0,
          res: '{default: '0}};
    dir.push_back(d);
    d = '{r: '{mshr_pkg::KIND_FLUSH, 32'h0, 32'h0, 16'h0, 3'd3}, fixed: 0,
          res: '{default: '0}};
    dir.push_back(d);
    d = '{r: '{mshr_pkg::KIND_TICK, 32'h0, 32'd100, 16'h0, 3'd0}, fixed: 0,
          res: '{default: '0}};
    dir.push_back(d);
    d = '{r: '{mshr_pkg::KIND_TICK, 32'h0, 32'hFFFF_FFFF, 16'h0, 3'd0}, fixed: 0,
          res: '{default: '0}};
    dir.push_back(d);
    foreach (dir[i]) send_req(dir[i].r, dir[i].fixed, dir[i].res);

    // offset width zero and oversized width
    write_offbits(4'd0);
    send_req('{mshr_pkg::KIND_INSERT, 32'h1234_5678, 32'd5, 16'd3, 3'd0});
    send_req('{mshr_pkg::KIND_INSERT, 32'h1234_5678, 32'd5, 16'd3, 3'd0});
    send_req('{mshr_pkg::KIND_LOOKUP, 32'h1234_5679, 32'd0, 16'd0, 3'd0});
    write_offbits(4'd15);
    send_req('{mshr_pkg::KIND_INSERT, 32'h1234_5000, 32'd5, 16'd3, 3'd0});
    send_req('{mshr_pkg::KIND_LOOKUP, 32'h1234_5FFF, 32'd0, 16'd0, 3'd0});
    send_req('{mshr_pkg::KIND_TICK, 32'h0, 32'hFFFF_FFFF, 16'd0, 3'd0});

    // random phases: idle patterns and offset widths
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: begin send_idle_pct = 26; recv_idle_pct = 68; end
        1: begin send_idle_pct = 68; recv_idle_pct = 26; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      write_offbits(ph == 0 ? 4'd1 : ph == 1 ? 4'd12 : ph == 2 ? 4'd6 :
                    4'($urandom_range(15)));
      for (int n = 0; n < 220; n++) begin
        if (n % 40 == 0) base = $urandom;
        // long receiver hold-off while requests keep coming
        if (ph == 2 && n == 50) begin
          fork
            begin
              hold_off = 1;
              repeat (200) @(posedge clk);
              hold_off = 0;
            end
          join_none
        end
        // sender pause until everything has come back
        if (n == 110) begin
          in_tvalid <= 1'b0;
          do @(posedge clk); while (expected_q.size() != 0);
        end
        send_req(rand_req(base, ($urandom_range(9) == 0) ? 1 : 0));
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    $display("Covered all request kinds, offset widths 0, 1, 6, 12, 15 and random,");
    $display("saturation, full and no-free cases under varied stalls; %0d results checked.",
             checked);
    if (errors == 0) begin
      $display("tb_miss_status_holding_registers: PASS");
    end else begin
      $display("tb_miss_status_holding_registers: FAIL");
    end
    $finish;
  end

endmodule
